/* src/mgpg_pkg.sv */
package mgpg_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_MODULES_DEF = 32;
  localparam int GRID_SIDE_DEF   = 6;
  localparam int GROUP_SIZE_DEF  = 5;

  // Fixed field widths.
  localparam int POS_W      = 24;
  localparam int IDX_W      = 11;
  localparam int CNT_W      = 6;
  localparam int MODNUM_W   = 6;
  localparam int MODNUM_MAX = 63;
  localparam int CNT_RESET  = 25;
  localparam int POS_MAX    = 8388607;

  // Corners are held at twice their value; the derived corners need 27 bits.
  localparam int CORNER_W = 27;

  // Width of a weighted corner sum for a given grid side.
  function automatic int acc_width(input int grid_side);
    return CORNER_W + $clog2((grid_side - 1) * (grid_side - 1) + 1);
  endfunction

  typedef struct packed {
    logic             load;
    logic             corners;
    logic             prep;
    logic             issue;
    logic             row_end;
    logic             last;
    logic [IDX_W-1:0] idx;
  } mgpg_cmd_t;

  typedef struct packed {
    logic pipe_ready;
  } mgpg_stat_t;

endpackage

/* src/mgpg_in_if.sv */
interface mgpg_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mgpg_pkg::POS_W-1:0] origin_x;
  logic signed [mgpg_pkg::POS_W-1:0] origin_y;
  logic signed [mgpg_pkg::POS_W-1:0] corner_x;
  logic signed [mgpg_pkg::POS_W-1:0] corner_y;
  logic                              first_module;

  modport source (
    output valid, origin_x, origin_y, corner_x, corner_y, first_module,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, corner_x, corner_y, first_module,
    output ready
  );
endinterface

/* src/mgpg_out_if.sv */
interface mgpg_out_if;
  logic                              valid;
  logic                              ready;
  logic [mgpg_pkg::IDX_W-1:0]        point_index;
  logic signed [mgpg_pkg::POS_W-1:0] pos_x;
  logic signed [mgpg_pkg::POS_W-1:0] pos_y;
  logic                              last_point;

  modport source (
    output valid, point_index, pos_x, pos_y, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_index, pos_x, pos_y, last_point,
    output ready
  );
endinterface

/* src/mgpg_div_pipe.sv */
module mgpg_div_pipe #(
  parameter int  GRID_SIDE = mgpg_pkg::GRID_SIDE_DEF,
  localparam int ACC_W     = mgpg_pkg::acc_width(GRID_SIDE)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ACC_W-1:0]           in_sx,
  input  logic signed [ACC_W-1:0]           in_sy,
  input  logic [mgpg_pkg::IDX_W-1:0]        in_idx,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mgpg_pkg::IDX_W-1:0]        out_idx,
  output logic signed [mgpg_pkg::POS_W-1:0] out_x,
  output logic signed [mgpg_pkg::POS_W-1:0] out_y,
  output logic                              out_last
);

  localparam int D     = GRID_SIDE - 1;
  localparam int DD    = D * D;
  localparam int NW    = ACC_W - 1;
  localparam int SH_L  = $clog2(DD);
  localparam int SHIFT = NW + SH_L;
  localparam int RCP_W = NW + 1;
  localparam int PW    = NW + RCP_W;
  localparam int QW    = PW - SHIFT;
  localparam int POS_W = mgpg_pkg::POS_W;
  localparam int IDX_W = mgpg_pkg::IDX_W;
  // Reciprocal of the squared span, rounded up; exact for every NW-bit dividend.
  localparam longint unsigned RCP_VAL =
    ((64'd1 << SHIFT) + 64'(DD) - 64'd1) / 64'(DD);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

  logic [1:0]       vld;
  logic [NW-1:0]    a_mag_x, a_mag_y;
  logic             a_neg_x, a_neg_y, a_last;
  logic [IDX_W-1:0] a_idx;
  logic [PW-1:0]    b_prod_x, b_prod_y;
  logic             b_neg_x, b_neg_y, b_last;
  logic [IDX_W-1:0] b_idx;
  logic             adv;

  // Magnitude plus the squared span, halved. Its floor quotient by the squared
  // span is the quotient by the full denominator, rounded half away from zero.
  function automatic logic [NW-1:0] half_mag(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] a;
    a = v[ACC_W-1] ? -v : v;
    a = a + ACC_W'(DD);
    return a[ACC_W-1:1];
  endfunction

  function automatic logic [POS_W-1:0] sat(input logic [QW-1:0] q, input logic neg);
    logic [POS_W-1:0] r;
    if (neg) begin
      if (q > QW'(mgpg_pkg::POS_MAX + 1)) r = {1'b1, {(POS_W-1){1'b0}}};
      else r = ~q[POS_W-1:0] + 1'b1;
    end else begin
      if (q > QW'(mgpg_pkg::POS_MAX)) r = {1'b0, {(POS_W-1){1'b1}}};
      else r = q[POS_W-1:0];
    end
    return r;
  endfunction

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
  end

  // Three stages: rounded magnitude, product with the reciprocal, then the
  // quotient with its sign restored and clamped in the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_x  <= half_mag(in_sx);
      a_mag_y  <= half_mag(in_sy);
      a_neg_x  <= in_sx[ACC_W-1];
      a_neg_y  <= in_sy[ACC_W-1];
      a_idx    <= in_idx;
      a_last   <= in_last;
      b_prod_x <= PW'(a_mag_x) * PW'(RCP);
      b_prod_y <= PW'(a_mag_y) * PW'(RCP);
      b_neg_x  <= a_neg_x;
      b_neg_y  <= a_neg_y;
      b_idx    <= a_idx;
      b_last   <= a_last;
      out_x    <= sat(b_prod_x[PW-1:SHIFT], b_neg_x);
      out_y    <= sat(b_prod_y[PW-1:SHIFT], b_neg_y);
      out_idx  <= b_idx;
      out_last <= b_last;
    end
  end

endmodule

/* src/mgpg_datapath.sv */
module mgpg_datapath #(
  parameter int  GRID_SIDE = mgpg_pkg::GRID_SIDE_DEF,
  localparam int ACC_W     = mgpg_pkg::acc_width(GRID_SIDE)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mgpg_pkg::mgpg_cmd_t               cmd,
  output mgpg_pkg::mgpg_stat_t              stat,
  input  logic signed [mgpg_pkg::POS_W-1:0] origin_x,
  input  logic signed [mgpg_pkg::POS_W-1:0] origin_y,
  input  logic signed [mgpg_pkg::POS_W-1:0] corner_x,
  input  logic signed [mgpg_pkg::POS_W-1:0] corner_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mgpg_pkg::IDX_W-1:0]        point_index,
  output logic signed [mgpg_pkg::POS_W-1:0] pos_x,
  output logic signed [mgpg_pkg::POS_W-1:0] pos_y,
  output logic                              last_point
);

  localparam int CW = mgpg_pkg::CORNER_W;
  localparam int D  = GRID_SIDE - 1;
  localparam logic signed [ACC_W-1:0] D_W  = ACC_W'(D);
  localparam logic signed [ACC_W-1:0] DD_W = ACC_W'(D * D);

  logic signed [mgpg_pkg::POS_W-1:0] ox, oy, tx, ty;
  logic signed [CW-1:0] oxe, oye, txe, tye, dx, dy;
  logic signed [CW-1:0] o2x, o2y, b2x, b2y, l2x, l2y, t2x, t2y;
  logic signed [ACC_W-1:0] rsx, rsy, sx, sy, rix, riy, dkx, dky, ddkx, ddky;
  logic pipe_ready;

  assign oxe = CW'(ox);
  assign oye = CW'(oy);
  assign txe = CW'(tx);
  assign tye = CW'(ty);
  assign dx  = txe - oxe;
  assign dy  = tye - oye;

  function automatic logic signed [ACC_W-1:0] wide(input logic signed [CW-1:0] v);
    return ACC_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox <= origin_x;
      oy <= origin_y;
      tx <= corner_x;
      ty <= corner_y;
    end
    // The four corners at twice their value, so the half offset stays exact.
    if (cmd.corners) begin
      o2x <= oxe + oxe;
      o2y <= oye + oye;
      b2x <= oxe + oxe + dx + dy;
      b2y <= oye + oye + dy - dx;
      l2x <= oxe + oxe + dx - dy;
      l2y <= oye + oye + dy + dx;
      t2x <= txe + txe;
      t2y <= tye + tye;
    end
    // Set up the forward differences of the bilinear sum.
    if (cmd.prep) begin
      rsx  <= wide(o2x) * DD_W;
      rsy  <= wide(o2y) * DD_W;
      sx   <= wide(o2x) * DD_W;
      sy   <= wide(o2y) * DD_W;
      rix  <= (wide(l2x) - wide(o2x)) * D_W;
      riy  <= (wide(l2y) - wide(o2y)) * D_W;
      dkx  <= (wide(b2x) - wide(o2x)) * D_W;
      dky  <= (wide(b2y) - wide(o2y)) * D_W;
      ddkx <= wide(t2x) - wide(l2x) - wide(b2x) + wide(o2x);
      ddky <= wide(t2y) - wide(l2y) - wide(b2y) + wide(o2y);
    end
    if (cmd.issue) begin
      if (cmd.row_end) begin
        rsx <= rsx + rix;
        rsy <= rsy + riy;
        sx  <= rsx + rix;
        sy  <= rsy + riy;
        dkx <= dkx + ddkx;
        dky <= dky + ddky;
      end else begin
        sx <= sx + dkx;
        sy <= sy + dky;
      end
    end
  end

  mgpg_div_pipe #(
    .GRID_SIDE (GRID_SIDE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.issue),
    .in_ready  (pipe_ready),
    .in_sx     (sx),
    .in_sy     (sy),
    .in_idx    (cmd.idx),
    .in_last   (cmd.last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_idx   (point_index),
    .out_x     (pos_x),
    .out_y     (pos_y),
    .out_last  (last_point)
  );

  assign stat.pipe_ready = pipe_ready;

endmodule

/* src/mgpg_ctrl.sv */
module mgpg_ctrl #(
  parameter int MAX_MODULES = mgpg_pkg::MAX_MODULES_DEF,
  parameter int GRID_SIDE   = mgpg_pkg::GRID_SIDE_DEF,
  parameter int GROUP_SIZE  = mgpg_pkg::GROUP_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       first_module,
  input  logic                       cfg_we,
  input  logic [mgpg_pkg::CNT_W-1:0] cfg_wdata,
  input  mgpg_pkg::mgpg_stat_t       stat,
  output mgpg_pkg::mgpg_cmd_t        cmd
);

  localparam int IDX_W    = mgpg_pkg::IDX_W;
  localparam int MODNUM_W = mgpg_pkg::MODNUM_W;
  localparam int D        = GRID_SIDE - 1;
  localparam int RC_W     = $clog2(GRID_SIDE);
  localparam int MIG_W    = $clog2(GROUP_SIZE + 1);
  localparam int GE_W     = $clog2(mgpg_pkg::MODNUM_MAX + GROUP_SIZE + 1);
  localparam logic [IDX_W-1:0] GROUP_STRIDE = IDX_W'(GROUP_SIZE * GRID_SIDE * GRID_SIDE);
  localparam logic [IDX_W-1:0] ROW_STEP     = IDX_W'(GROUP_SIZE * GRID_SIDE - D);
  localparam logic [IDX_W-1:0] MOD_STEP     = IDX_W'(GRID_SIDE);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CORNER = 4'b0010,
    ST_PREP   = 4'b0100,
    ST_RUN    = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [mgpg_pkg::CNT_W-1:0] count;
  logic [MODNUM_W-1:0]     module_number;
  logic [MIG_W-1:0]        mig;
  logic [IDX_W-1:0]        mig_off;
  logic [GE_W-1:0]         grp_end;
  logic [IDX_W-1:0]        grp_base;
  logic [RC_W-1:0]         row, col;
  logic [IDX_W-1:0]        pt_idx;

  logic [MODNUM_W-1:0]     num_sel;
  logic [MIG_W-1:0]        mig_sel;
  logic [IDX_W-1:0]        mig_off_sel;
  logic [GE_W-1:0]         ge_sel;
  logic [IDX_W-1:0]        base_sel;
  logic [GE_W-1:0]         eff_cnt;
  logic                    accept, skip, last_col, last_row;

  // A new set restarts the numbering; otherwise the running counters stand.
  assign num_sel     = first_module ? '0 : module_number;
  assign mig_sel     = first_module ? '0 : mig;
  assign mig_off_sel = first_module ? '0 : mig_off;
  assign ge_sel      = first_module ? GE_W'(GROUP_SIZE) : grp_end;
  assign base_sel    = first_module ? '0 : grp_base;

  assign eff_cnt = (GE_W'(count) > GE_W'(MAX_MODULES)) ? GE_W'(MAX_MODULES) : GE_W'(count);
  // The module's group ends beyond the set: no points. This also covers a
  // module number at or beyond the count, since the group end exceeds it.
  assign skip    = ge_sel > eff_cnt;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_col = (col == RC_W'(D));
  assign last_row = (row == RC_W'(D));

  always_comb begin
    cmd         = '0;
    cmd.load    = accept;
    cmd.corners = (state == ST_CORNER);
    cmd.prep    = (state == ST_PREP);
    cmd.issue   = (state == ST_RUN) && stat.pipe_ready;
    cmd.row_end = last_col;
    cmd.last    = last_col && last_row;
    cmd.idx     = pt_idx;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && !skip) state_next = ST_CORNER;
      ST_CORNER: state_next = ST_PREP;
      ST_PREP:   state_next = ST_RUN;
      ST_RUN:    if (cmd.issue && cmd.last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= mgpg_pkg::CNT_W'(mgpg_pkg::CNT_RESET);
      module_number <= '0;
      mig           <= '0;
      mig_off       <= '0;
      grp_end       <= GE_W'(GROUP_SIZE);
      grp_base      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) count <= cfg_wdata;
      if (accept) begin
        module_number <= num_sel;
        mig           <= mig_sel;
        mig_off       <= mig_off_sel;
        grp_end       <= ge_sel;
        grp_base      <= base_sel;
        // The number sticks at its top value, and the group counters with it.
        if (num_sel != MODNUM_W'(mgpg_pkg::MODNUM_MAX)) begin
          module_number <= num_sel + 1'b1;
          if (mig_sel == MIG_W'(GROUP_SIZE - 1)) begin
            mig      <= '0;
            mig_off  <= '0;
            grp_end  <= ge_sel + GE_W'(GROUP_SIZE);
            grp_base <= base_sel + GROUP_STRIDE;
          end else begin
            mig     <= mig_sel + 1'b1;
            mig_off <= mig_off_sel + MOD_STEP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row    <= '0;
      col    <= '0;
      pt_idx <= base_sel + mig_off_sel;
    end else if (cmd.issue) begin
      if (last_col) begin
        col    <= '0;
        row    <= row + 1'b1;
        pt_idx <= pt_idx + ROW_STEP;
      end else begin
        col    <= col + 1'b1;
        pt_idx <= pt_idx + 1'b1;
      end
    end
  end

endmodule

/* src/module_grid_point_generator_unit.sv */
// Module grid point generator.
//
// The modules channel takes one transaction per square module: its origin
// corner, its opposite corner and a flag that restarts module numbering. For
// every module that lies in a complete group within module_count (capped at
// MAX_MODULES), the points channel delivers GRID_SIDE*GRID_SIDE transactions,
// row by row, each with its global point index, the bilinearly interpolated
// position (rounded half away from zero, saturated to 24 bits) and a flag on
// the last. A module outside a complete group is taken and produces nothing.
// Timing: after a transaction is taken, the corners and then the difference
// terms are derived, then one point per cycle enters the division pipeline
// while the pipeline can take it; a new module is taken only once the last
// point of the module before has entered the pipeline, and a module that
// yields no points leaves the unit idle and ready. The division is a
// multiplication by the reciprocal over three stages, the last being the
// output register, from which the points channel is driven.
// Reset empties the pipeline, clears the module number and loads a module
// count of 25. When the receiver stalls, the whole pipeline holds and point
// issue waits; nothing is dropped. cfg_we writes module_count.
module module_grid_point_generator_unit #(
  parameter int MAX_MODULES = mgpg_pkg::MAX_MODULES_DEF,
  parameter int GRID_SIDE   = mgpg_pkg::GRID_SIDE_DEF,
  parameter int GROUP_SIZE  = mgpg_pkg::GROUP_SIZE_DEF
) (
  input logic                       clk,
  input logic                       rst,
  mgpg_in_if.sink                   modules,
  mgpg_out_if.source                points,
  input logic                       cfg_we,
  input logic [mgpg_pkg::CNT_W-1:0] cfg_wdata
);

  // Command and status between the sequencer and the arithmetic.
  mgpg_pkg::mgpg_cmd_t  cmd;
  mgpg_pkg::mgpg_stat_t stat;

  // The controller owns module numbering, the module count register, the
  // grid row and column counters and the point index.
  mgpg_ctrl #(
    .MAX_MODULES (MAX_MODULES),
    .GRID_SIDE   (GRID_SIDE),
    .GROUP_SIZE  (GROUP_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (modules.valid),
    .in_ready     (modules.ready),
    .first_module (modules.first_module),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .stat         (stat),
    .cmd          (cmd)
  );

  // The datapath steps the weighted corner sums by forward differences and
  // divides each by twice the squared grid span in its pipeline, whose last
  // stage is the output register of the points channel.
  mgpg_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .origin_x    (modules.origin_x),
    .origin_y    (modules.origin_y),
    .corner_x    (modules.corner_x),
    .corner_y    (modules.corner_y),
    .out_valid   (points.valid),
    .out_ready   (points.ready),
    .point_index (points.point_index),
    .pos_x       (points.pos_x),
    .pos_y       (points.pos_y),
    .last_point  (points.last_point)
  );

endmodule
